@@ rtl/bfc_pkg.sv @@
package bfc_pkg;

  localparam int MAX_FRAME_BYTES = 32;
  localparam int HEAD_DEPTH      = 5;
  localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
  localparam int HEAD_IDX_W      = $clog2(HEAD_DEPTH);

  localparam logic KIND_CLOCK = 1'b0;
  localparam logic KIND_BUSY  = 1'b1;

  localparam logic [7:0] BYTE_ID_LEAD  = 8'h07;
  localparam logic [7:0] BYTE_19       = 8'h19;
  localparam logic [7:0] BYTE_1A       = 8'h1A;
  localparam logic [7:0] BYTE_1B       = 8'h1B;
  localparam logic [7:0] BYTE_1E       = 8'h1E;
  localparam logic [7:0] BYTE_2F       = 8'h2F;
  localparam logic [7:0] BYTE_29       = 8'h29;
  localparam logic [7:0] BYTE_52       = 8'h52;
  localparam logic [7:0] BYTE_22       = 8'h22;
  localparam logic [7:0] BYTE_2D       = 8'h2D;
  localparam logic [7:0] BYTE_40       = 8'h40;
  localparam logic [7:0] BYTE_00       = 8'h00;
  localparam logic [7:0] BYTE_01       = 8'h01;
  localparam logic [7:0] BYTE_50       = 8'h50;
  localparam logic [7:0] BYTE_41       = 8'h41;
  localparam logic [7:0] BYTE_E0       = 8'hE0;
  localparam logic [7:0] BYTE_EF       = 8'hEF;
  localparam logic [7:0] BYTE_ED       = 8'hED;
  localparam logic [7:0] BYTE_80       = 8'h80;
  localparam logic [7:0] BYTE_86       = 8'h86;
  localparam logic [7:0] BYTE_EE       = 8'hEE;

  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_FR        = 4'd1,
    CMD_FF        = 4'd2,
    CMD_RND       = 4'd3,
    CMD_POWERDOWN = 4'd4,
    CMD_TRK_UP    = 4'd5,
    CMD_TRK_DN    = 4'd6,
    CMD_DISC_NEXT = 4'd7,
    CMD_DISC_DN   = 4'd8,
    CMD_INFO_1B   = 4'd9,
    CMD_INFO_1A   = 4'd10,
    CMD_CHG_INFO  = 4'd11,
    CMD_CD_INIT   = 4'd12,
    CMD_ID_REQ    = 4'd13
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic data_bit;
    logic busy_level;
  } req_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       frame_done;
    cmd_t       command;
    logic [5:0] frame_length;
    logic       overflow;
  } rsp_t;

  typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

endpackage

@@ rtl/bfc_cmd_match.sv @@
module bfc_cmd_match (
  input  bfc_pkg::head_t                  head,
  input  logic [bfc_pkg::COUNT_W-1:0]     count,
  output bfc_pkg::cmd_t                   command
);
  import bfc_pkg::*;

  logic [HEAD_DEPTH-1:0] seen;

  always_comb begin
    for (int k = 0; k < HEAD_DEPTH; k++) begin
      seen[k] = count > COUNT_W'(k);
    end
  end

  function automatic logic is_byte(head_t h, logic [HEAD_DEPTH-1:0] s, int k,
                                   logic [7:0] v);
    return s[k[HEAD_IDX_W-1:0]] && (h[k[HEAD_IDX_W-1:0]] == v);
  endfunction

  always_comb begin
    if (is_byte(head, seen, 1, BYTE_19) && is_byte(head, seen, 2, BYTE_2F)) begin
      command = CMD_FR;
    end else if (is_byte(head, seen, 1, BYTE_19) && is_byte(head, seen, 2, BYTE_29)) begin
      command = CMD_FF;
    end else if (is_byte(head, seen, 1, BYTE_19) && is_byte(head, seen, 2, BYTE_52)) begin
      command = CMD_RND;
    end else if (is_byte(head, seen, 1, BYTE_19) && is_byte(head, seen, 2, BYTE_22)) begin
      command = CMD_POWERDOWN;
    end else if (is_byte(head, seen, 1, BYTE_1B) && is_byte(head, seen, 2, BYTE_2D) &&
                 is_byte(head, seen, 3, BYTE_40) && is_byte(head, seen, 4, BYTE_01)) begin
      command = CMD_TRK_UP;
    end else if (is_byte(head, seen, 1, BYTE_1B) && is_byte(head, seen, 2, BYTE_2D) &&
                 is_byte(head, seen, 3, BYTE_00) && is_byte(head, seen, 4, BYTE_01)) begin
      command = CMD_TRK_DN;
    end else if (is_byte(head, seen, 1, BYTE_1A) && is_byte(head, seen, 2, BYTE_50) &&
                 is_byte(head, seen, 3, BYTE_41)) begin
      command = CMD_DISC_NEXT;
    end else if (is_byte(head, seen, 1, BYTE_1A) && is_byte(head, seen, 2, BYTE_50) &&
                 is_byte(head, seen, 3, BYTE_01)) begin
      command = CMD_DISC_DN;
    end else if (is_byte(head, seen, 1, BYTE_1B) && is_byte(head, seen, 2, BYTE_E0)) begin
      command = CMD_INFO_1B;
    end else if (is_byte(head, seen, 1, BYTE_1A) && is_byte(head, seen, 2, BYTE_E0)) begin
      command = CMD_INFO_1A;
    end else if (is_byte(head, seen, 1, BYTE_1E) && is_byte(head, seen, 2, BYTE_EF)) begin
      command = CMD_CHG_INFO;
    end else if (is_byte(head, seen, 2, BYTE_ED) && is_byte(head, seen, 3, BYTE_80) &&
                 is_byte(head, seen, 4, BYTE_86)) begin
      command = CMD_CD_INIT;
    end else if (is_byte(head, seen, 0, BYTE_ID_LEAD) && is_byte(head, seen, 1, BYTE_1A) &&
                 is_byte(head, seen, 2, BYTE_EE)) begin
      command = CMD_ID_REQ;
    end else begin
      command = CMD_NONE;
    end
  end

endmodule

@@ rtl/bus_frame_capture_and_command_match.sv @@
// Latency: a result beat is valid in the cycle after its event beat is accepted.
// Throughput: one event beat per cycle; the result register frees itself when the
// result is taken in the same cycle, so the block stalls only while the output stalls.
// Reset (rst, synchronous, active high) empties the result register, clears the
// frame state, sets the bit position to seven, marks the bus idle and zeroes the id.
module bus_frame_capture_and_command_match (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bfc_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bfc_pkg::rsp_t   rsp,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data
);
  import bfc_pkg::*;

  logic [7:0]         responder_id;
  head_t              head_bytes;
  logic [7:0]         last_byte;
  logic [7:0]         prior_byte;
  logic [7:0]         shift_byte;
  logic [COUNT_W-1:0] byte_count;
  logic [2:0]         bit_position;
  logic               busy_low;
  logic               overflowed;

  logic [7:0]         shift_byte_next;
  logic [COUNT_W-1:0] byte_count_next;
  logic [2:0]         bit_position_next;
  logic               busy_low_next;
  logic               overflowed_next;
  logic               store;
  logic               room;
  logic               respond;
  logic               bit_in;
  logic               accept;
  cmd_t               match;
  rsp_t               rsp_next;

  bfc_cmd_match u_match (
    .head    (head_bytes),
    .count   (byte_count),
    .command (match)
  );

  assign accept    = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;
  assign room      = byte_count < COUNT_W'(MAX_FRAME_BYTES);

  assign respond = (byte_count > COUNT_W'(3)) && (head_bytes[0] == BYTE_ID_LEAD) &&
                   (last_byte == responder_id) && (prior_byte != responder_id);
  assign bit_in  = respond ? responder_id[bit_position] : req.data_bit;

  always_comb begin
    shift_byte_next   = shift_byte;
    byte_count_next   = byte_count;
    bit_position_next = bit_position;
    busy_low_next     = busy_low;
    overflowed_next   = overflowed;
    store             = 1'b0;
    rsp_next          = '0;
    if (req.kind == KIND_CLOCK) begin
      if (busy_low) begin
        rsp_next.drive_enable = respond;
        rsp_next.drive_level  = respond && bit_in;
        shift_byte_next[bit_position] = bit_in;
        if (bit_position == 3'd0) begin
          bit_position_next = 3'd7;
          if (room) begin
            store           = 1'b1;
            byte_count_next = byte_count + COUNT_W'(1);
          end else begin
            overflowed_next = 1'b1;
          end
        end else begin
          bit_position_next = bit_position - 3'd1;
        end
      end
    end else if (!req.busy_level) begin
      busy_low_next     = 1'b1;
      byte_count_next   = '0;
      bit_position_next = 3'd7;
      shift_byte_next   = '0;
      overflowed_next   = 1'b0;
    end else begin
      busy_low_next = 1'b0;
      if (busy_low && (byte_count != '0)) begin
        rsp_next.frame_done   = 1'b1;
        rsp_next.command      = match;
        rsp_next.frame_length = 6'(byte_count);
        rsp_next.overflow     = overflowed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      responder_id <= '0;
      shift_byte   <= '0;
      byte_count   <= '0;
      bit_position <= 3'd7;
      busy_low     <= 1'b0;
      overflowed   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        responder_id <= cfg_data;
      end
      if (accept) begin
        shift_byte   <= shift_byte_next;
        byte_count   <= byte_count_next;
        bit_position <= bit_position_next;
        busy_low     <= busy_low_next;
        overflowed   <= overflowed_next;
        rsp_valid    <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
      if (store) begin
        prior_byte <= last_byte;
        last_byte  <= shift_byte_next;
        if (byte_count < COUNT_W'(HEAD_DEPTH)) begin
          head_bytes[byte_count[HEAD_IDX_W-1:0]] <= shift_byte_next;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(MAX_FRAME_BYTES))
    else $error("byte count passed the buffer size");

  a_drive_not_report: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.drive_enable |-> !rsp.frame_done)
    else $error("driven bit and frame report in one beat");

  a_idle_clock_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && (req.kind == KIND_CLOCK) && !busy_low |=> rsp_valid && (rsp == '0))
    else $error("clock edge while idle gave a nonzero result");

  a_no_report_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.frame_done |->
      (rsp.command == CMD_NONE) && (rsp.frame_length == 6'd0) && !rsp.overflow)
    else $error("report fields set without a finished frame");

endmodule

@@ sim/bus_frame_capture_and_command_match_test.sv @@
module bus_frame_capture_and_command_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfc_pkg::*;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  bus_frame_capture_and_command_match dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  req_t bus_events[$];
  rsp_t predicted_replies[$];
  logic [7:0] frame_bytes[$];

  int sender_idle_pct = 0;
  int rcv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  logic [7:0] active_id = 8'h00;

  int mismatches = 0;
  int events_queued = 0;
  int events_taken = 0;
  int beats_checked = 0;
  int frames_reported = 0;
  int driven_bits = 0;
  int overflow_frames = 0;
  int id_settings = 0;
  logic [15:0] commands_seen = '0;

  // Shadow of the block's frame state and its register.
  logic [7:0] id_seen;
  logic [7:0] head_seen [HEAD_DEPTH];
  logic [7:0] last_seen;
  logic [7:0] prior_seen;
  logic [7:0] shift_seen;
  int frame_bytes_seen;
  int bit_pos_seen;
  logic bus_active;
  logic dropped;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic head_is(int k, logic [7:0] v);
    return k < HEAD_DEPTH && k < frame_bytes_seen && head_seen[k] == v;
  endfunction

  function automatic cmd_t predict_command();
    if (head_is(1, BYTE_19) && head_is(2, BYTE_2F)) return CMD_FR;
    if (head_is(1, BYTE_19) && head_is(2, BYTE_29)) return CMD_FF;
    if (head_is(1, BYTE_19) && head_is(2, BYTE_52)) return CMD_RND;
    if (head_is(1, BYTE_19) && head_is(2, BYTE_22)) return CMD_POWERDOWN;
    if (head_is(1, BYTE_1B) && head_is(2, BYTE_2D) && head_is(3, BYTE_40) && head_is(4, BYTE_01))
      return CMD_TRK_UP;
    if (head_is(1, BYTE_1B) && head_is(2, BYTE_2D) && head_is(3, BYTE_00) && head_is(4, BYTE_01))
      return CMD_TRK_DN;
    if (head_is(1, BYTE_1A) && head_is(2, BYTE_50) && head_is(3, BYTE_41)) return CMD_DISC_NEXT;
    if (head_is(1, BYTE_1A) && head_is(2, BYTE_50) && head_is(3, BYTE_01)) return CMD_DISC_DN;
    if (head_is(1, BYTE_1B) && head_is(2, BYTE_E0)) return CMD_INFO_1B;
    if (head_is(1, BYTE_1A) && head_is(2, BYTE_E0)) return CMD_INFO_1A;
    if (head_is(1, BYTE_1E) && head_is(2, BYTE_EF)) return CMD_CHG_INFO;
    if (head_is(2, BYTE_ED) && head_is(3, BYTE_80) && head_is(4, BYTE_86)) return CMD_CD_INIT;
    if (head_is(0, BYTE_ID_LEAD) && head_is(1, BYTE_1A) && head_is(2, BYTE_EE)) return CMD_ID_REQ;
    return CMD_NONE;
  endfunction

  function automatic rsp_t bus_event_response(req_t ev);
    rsp_t r;
    logic bit_v;
    int p;
    r = '0;
    if (ev.kind == KIND_CLOCK) begin
      if (bus_active) begin
        p = bit_pos_seen;
        if (frame_bytes_seen > 3 && head_is(0, BYTE_ID_LEAD) &&
            last_seen == id_seen && prior_seen != id_seen) begin
          bit_v = id_seen[p];
          r.drive_enable = 1'b1;
          r.drive_level = bit_v;
        end else begin
          bit_v = ev.data_bit;
        end
        shift_seen[p] = bit_v;
        if (p == 0) begin
          if (frame_bytes_seen >= MAX_FRAME_BYTES) begin
            dropped = 1'b1;
          end else begin
            if (frame_bytes_seen < HEAD_DEPTH) head_seen[frame_bytes_seen] = shift_seen;
            prior_seen = last_seen;
            last_seen = shift_seen;
            frame_bytes_seen++;
          end
          bit_pos_seen = 7;
        end else begin
          bit_pos_seen = p - 1;
        end
      end
    end else if (ev.busy_level == 1'b0) begin
      bus_active = 1'b1;
      frame_bytes_seen = 0;
      bit_pos_seen = 7;
      shift_seen = 8'h00;
      dropped = 1'b0;
    end else begin
      if (bus_active && frame_bytes_seen >= 1) begin
        r.frame_done = 1'b1;
        r.command = predict_command();
        r.frame_length = 6'(frame_bytes_seen);
        r.overflow = dropped;
      end
      bus_active = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t ns, result beat %0d: %s", $time, beats_checked, what);
    mismatches++;
  endtask

  task automatic compare_beat(rsp_t got, rsp_t want);
    if (got.drive_enable !== want.drive_enable)
      report_mismatch($sformatf("drive_enable %b, expected %b", got.drive_enable,
                                want.drive_enable));
    if (got.drive_level !== want.drive_level)
      report_mismatch($sformatf("drive_level %b, expected %b", got.drive_level,
                                want.drive_level));
    if (got.frame_done !== want.frame_done)
      report_mismatch($sformatf("frame_done %b, expected %b", got.frame_done, want.frame_done));
    if (got.command !== want.command)
      report_mismatch($sformatf("command %0d, expected %0d", got.command, want.command));
    if (got.frame_length !== want.frame_length)
      report_mismatch($sformatf("frame_length %0d, expected %0d", got.frame_length,
                                want.frame_length));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      req_valid <= 1'b0;
      id_seen = 8'h00;
      for (int i = 0; i < HEAD_DEPTH; i++) head_seen[i] = 8'h00;
      last_seen = 8'h00;
      prior_seen = 8'h00;
      shift_seen = 8'h00;
      frame_bytes_seen = 0;
      bit_pos_seen = 7;
      bus_active = 1'b0;
      dropped = 1'b0;
    end else begin
      if (cfg_we) id_seen = cfg_data;
      if (req_valid && req_ready) begin
        predicted_replies.push_back(bus_event_response(req));
        events_taken++;
      end
      if (!req_valid || req_ready) begin
        if (bus_events.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          req <= bus_events.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("result beat arrived with nothing expected");
        end else begin
          want = predicted_replies.pop_front();
          compare_beat(rsp, want);
          if (want.frame_done) begin
            frames_reported++;
            commands_seen[want.command] = 1'b1;
            if (want.overflow) overflow_frames++;
          end
          if (want.drive_enable) driven_bits++;
        end
        beats_checked++;
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 200;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic push_event(logic k, logic d, logic b);
    req_t e;
    e.kind = k;
    e.data_bit = d;
    e.busy_level = b;
    bus_events.push_back(e);
    events_queued++;
  endtask

  task automatic push_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) push_event(KIND_CLOCK, b[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic push_busy(logic level);
    push_event(KIND_BUSY, 1'($urandom_range(0, 1)), level);
  endtask

  task automatic queue_frame();
    int r;
    if ($urandom_range(0, 19) == 0) push_busy(1'b0);
    push_busy(1'b0);
    foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 7)) push_event(KIND_CLOCK, 1'($urandom_range(0, 1)), 1'b0);
      push_busy(1'b1);
    end else if (r >= 12) begin
      push_busy(1'b1);
    end
  endtask

  task automatic queue_random_frame();
    int sel;
    int len;
    logic [7:0] pat [5];
    frame_bytes.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 6))
        push_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      return;
    end
    sel = $urandom_range(0, 15);
    for (int i = 0; i < 5; i++) pat[i] = 8'($urandom_range(0, 255));
    if (sel <= 12) begin
      case (cmd_t'(sel + 1))
        CMD_FR:        begin pat[1] = BYTE_19; pat[2] = BYTE_2F; end
        CMD_FF:        begin pat[1] = BYTE_19; pat[2] = BYTE_29; end
        CMD_RND:       begin pat[1] = BYTE_19; pat[2] = BYTE_52; end
        CMD_POWERDOWN: begin pat[1] = BYTE_19; pat[2] = BYTE_22; end
        CMD_TRK_UP: begin
          pat[1] = BYTE_1B; pat[2] = BYTE_2D; pat[3] = BYTE_40; pat[4] = BYTE_01;
        end
        CMD_TRK_DN: begin
          pat[1] = BYTE_1B; pat[2] = BYTE_2D; pat[3] = BYTE_00; pat[4] = BYTE_01;
        end
        CMD_DISC_NEXT: begin pat[1] = BYTE_1A; pat[2] = BYTE_50; pat[3] = BYTE_41; end
        CMD_DISC_DN:  begin pat[1] = BYTE_1A; pat[2] = BYTE_50; pat[3] = BYTE_01; end
        CMD_INFO_1B:  begin pat[1] = BYTE_1B; pat[2] = BYTE_E0; end
        CMD_INFO_1A:  begin pat[1] = BYTE_1A; pat[2] = BYTE_E0; end
        CMD_CHG_INFO: begin pat[1] = BYTE_1E; pat[2] = BYTE_EF; end
        CMD_CD_INIT:  begin pat[2] = BYTE_ED; pat[3] = BYTE_80; pat[4] = BYTE_86; end
        default:      begin pat[0] = BYTE_ID_LEAD; pat[1] = BYTE_1A; pat[2] = BYTE_EE; end
      endcase
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      for (int i = 0; i < len; i++)
        frame_bytes.push_back(i < 5 ? pat[i] : 8'($urandom_range(0, 255)));
    end else if (sel <= 14) begin
      // The byte after the id is answered, so its sampled bits are don't-cares.
      frame_bytes.push_back(BYTE_ID_LEAD);
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(active_id ^ 8'($urandom_range(1, 255)));
      frame_bytes.push_back(active_id);
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 35) : $urandom_range(1, 10);
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    queue_frame();
  endtask

  task automatic queue_traffic(int budget);
    int start;
    start = events_queued;
    while (events_queued - start < budget) queue_random_frame();
  endtask

  task automatic wait_idle();
    while (bus_events.size() != 0 || req_valid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_responder_id(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    active_id = v;
    id_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int sender_tbl [4];
    int rcv_tbl [4];
    logic [7:0] id_tbl [4];
    sender_tbl = '{0, 77, 0, 21};
    rcv_tbl = '{0, 0, 77, 21};
    id_tbl = '{8'hFF, 8'($urandom_range(1, 254)), 8'h00, 8'($urandom_range(1, 254))};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_responder_id(8'h00);

    // Clock edges and a busy rise while the bus is idle are ignored.
    push_event(KIND_CLOCK, 1'b0, 1'b0);
    push_event(KIND_CLOCK, 1'b1, 1'b1);
    push_busy(1'b1);
    // Busy falls twice, then a one-byte frame is reported.
    push_busy(1'b0);
    push_busy(1'b0);
    push_byte(BYTE_ID_LEAD);
    push_busy(1'b1);
    // A partial byte alone gives no report.
    push_busy(1'b0);
    repeat (3) push_event(KIND_CLOCK, 1'b1, 1'b0);
    push_busy(1'b1);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      set_responder_id(id_tbl[p]);
      sender_idle_pct <= sender_tbl[p];
      rcv_stall_pct <= rcv_tbl[p];
      if (p == 3) begin
        frame_bytes.delete();
        repeat (MAX_FRAME_BYTES + 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
        queue_frame();
        push_busy(1'b1);
      end else begin
        queue_traffic(70);
      end
      wait_idle();
      if (p == 0) begin
        // The receiver holds off while the sender keeps offering beats.
        queue_traffic(60);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        wait_idle();
      end
    end

    repeat (8) @(posedge clk);
    if (predicted_replies.size() != 0) report_mismatch("expected results never arrived");
    $display("Run covered %0d event beats and %0d result beats over %0d responder id settings.",
             events_taken, beats_checked, id_settings);
    $display("It saw %0d frame reports, %0d distinct commands, %0d driven bits, %0d overflows.",
             frames_reported, $countones(commands_seen), driven_bits, overflow_frames);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bfc_pkg.sv
rtl/bfc_cmd_match.sv
rtl/bus_frame_capture_and_command_match.sv
sim/bus_frame_capture_and_command_match_test.sv
